FILE: design/bcs_pkg.sv
// shared constants and transfer types for the bhattacharyya coefficient stream
`timescale 1ns / 1ps
`default_nettype none
package bcs_pkg;

    localparam int VALUE_BITS     = 32;
    localparam int MAX_PAIRS_LOG2 = 16;
    localparam int ACC_BITS       = VALUE_BITS + MAX_PAIRS_LOG2;
    localparam int PROD_BITS      = 2 * VALUE_BITS;
    localparam int FRAC_BITS      = 16;
    localparam int SIM_BITS       = FRAC_BITS + 1;
    localparam int BIG_BITS       = 2 * ACC_BITS;
    localparam int CMP_BITS       = 2 * ACC_BITS + 2 * FRAC_BITS + 3;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_AW       = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [31:0] u_value;
        logic [31:0] v_value;
        logic        last_pair;
    } t_in_item;

    typedef struct packed {
        logic [16:0] similarity;
        logic        empty_vector;
    } t_out_item;

endpackage
`default_nettype wire

FILE: design/bhattacharyya_coefficient_stream_top.sv
// top level of the bhattacharyya coefficient stream
//
//  channel  direction  handshake                  payload
//  input    in         i_in_valid / o_in_ready    i_in_data  (u_value, v_value, last_pair)
//  output   out        o_out_valid / i_out_ready  o_out_data (similarity, empty_vector)
//
// each pair takes one load, 32 square root steps and one add in the back end
// a last pair adds a hand-over step, and with nonzero sums first 2 x 48 shift-add
// multiply steps and 17 search steps; the hand-over waits while the output is stalled
// a four-entry queue keeps taking pairs until full while the back end works or the output stalls
// synchronous active-low reset clears the queue, the sums and the output valid flag
`timescale 1ns / 1ps
`default_nettype none
module bhattacharyya_coefficient_stream_top
    import bcs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_out_valid,
    input  wire logic     i_out_ready,
    output t_out_item     o_out_data
);

    logic     item_valid, item_ready;
    t_in_item item;

    bcs_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_ready (item_ready)
    );

    bcs_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_ready (item_ready),
        .o_out_valid  (o_out_valid),
        .o_out_data   (o_out_data),
        .i_out_ready  (i_out_ready)
    );

endmodule
`default_nettype wire

FILE: design/bcs_front.sv
// input queue between the handshake front and the arithmetic back end
`timescale 1ns / 1ps
`default_nettype none
module bcs_front
    import bcs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_ready,
    input  wire t_in_item i_in_data,
    output logic          o_item_valid,
    output t_in_item      o_item,
    input  wire logic     i_item_ready
);

    t_in_item                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]       r_count;
    logic                    push, pop;

    assign o_in_ready   = (r_count != QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH)) ;
    assign o_item_valid = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];
    assign push         = i_in_valid && o_in_ready;
    assign pop          = o_item_valid && i_item_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: design/bcs_back.sv
// root, accumulation and ratio search engine
`timescale 1ns / 1ps
`default_nettype none
module bcs_back
    import bcs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_item_valid,
    input  wire t_in_item i_item,
    output logic          o_item_ready,
    output logic          o_out_valid,
    output t_out_item     o_out_data,
    input  wire logic     i_out_ready
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_ROOT = 3'd1;
    localparam logic [2:0] ST_ACC  = 3'd2;
    localparam logic [2:0] ST_MULP = 3'd3;
    localparam logic [2:0] ST_MULS = 3'd4;
    localparam logic [2:0] ST_SRCH = 3'd5;
    localparam logic [2:0] ST_DONE = 3'd6;

    localparam int ICW = $clog2(VALUE_BITS);
    localparam int MCW = $clog2(ACC_BITS);

    logic [2:0]            r_state;
    logic [ACC_BITS-1:0]   r_sum_f, r_sum_s, r_sum_r;
    logic                  r_last;
    // integer square root
    logic [PROD_BITS-1:0]  r_x, r_r, r_bit;
    logic [ICW-1:0]        r_icnt;
    // shift-add multiplier
    logic [BIG_BITS-1:0]   r_ma, r_macc;
    logic [ACC_BITS-1:0]   r_mb;
    logic [MCW-1:0]        r_mcnt;
    // ratio search
    logic [BIG_BITS-1:0]   r_p;
    logic [CMP_BITS-1:0]   r_s, r_t, r_e, r_rr;
    logic [SIM_BITS-1:0]   r_q, r_qbit;
    // result
    logic [SIM_BITS-1:0]   r_sim;
    logic                  r_empty;
    logic                  r_ov;
    t_out_item             r_out;

    logic [PROD_BITS-1:0]  trial;
    logic [ACC_BITS:0]     add_f, add_s, add_r;
    logic [ACC_BITS-1:0]   n_sum_f, n_sum_s, n_sum_r;
    logic [CMP_BITS-1:0]   cand;
    logic                  take;
    logic                  out_free;
    logic                  n_ov;

    assign o_item_ready = (r_state == ST_IDLE);
    assign o_out_valid  = r_ov;
    assign o_out_data   = r_out;
    assign out_free     = !r_ov || i_out_ready;
    assign n_ov         = (r_state == ST_DONE && out_free) || (r_ov && !i_out_ready);

    assign trial = r_r + r_bit;

    assign add_f   = {1'b0, r_sum_f} + (ACC_BITS+1)'(r_ma[VALUE_BITS-1:0]);
    assign add_s   = {1'b0, r_sum_s} + (ACC_BITS+1)'(r_mb[VALUE_BITS-1:0]);
    assign add_r   = {1'b0, r_sum_r} + (ACC_BITS+1)'(r_r[VALUE_BITS-1:0]);
    // saturate on carry out
    assign n_sum_f = add_f[ACC_BITS] ? '1 : add_f[ACC_BITS-1:0];
    assign n_sum_s = add_s[ACC_BITS] ? '1 : add_s[ACC_BITS-1:0];
    assign n_sum_r = add_r[ACC_BITS] ? '1 : add_r[ACC_BITS-1:0];

    // q'^2 p = q^2 p + q p 2^(k+1) + p 2^(2k)
    assign cand = r_t + r_e + r_rr;
    assign take = !r_q[FRAC_BITS] && (cand <= r_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_sum_f <= '0;
            r_sum_s <= '0;
            r_sum_r <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_ov <= n_ov;
            case (r_state)
                ST_IDLE: begin
                    if (i_item_valid) begin
                        // weights parked in the multiplier operands until accumulation
                        r_ma   <= BIG_BITS'(i_item.u_value[VALUE_BITS-1:0]);
                        r_mb   <= ACC_BITS'(i_item.v_value[VALUE_BITS-1:0]);
                        r_last <= i_item.last_pair;
                        r_x    <= PROD_BITS'(i_item.u_value[VALUE_BITS-1:0])
                                * PROD_BITS'(i_item.v_value[VALUE_BITS-1:0]);
                        r_r    <= '0;
                        r_bit  <= PROD_BITS'(1) << (PROD_BITS - 2);
                        r_icnt <= '0;
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (r_x >= trial) begin
                        r_x <= r_x - trial;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit  <= r_bit >> 2;
                    r_icnt <= r_icnt + 1'b1;
                    if (r_icnt == ICW'(VALUE_BITS - 1)) begin
                        r_state <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    r_sum_f <= n_sum_f;
                    r_sum_s <= n_sum_s;
                    r_sum_r <= n_sum_r;
                    r_sim   <= '0;
                    r_empty <= (n_sum_f == '0) || (n_sum_s == '0);
                    r_ma    <= BIG_BITS'(n_sum_f);
                    r_mb    <= n_sum_s;
                    r_macc  <= '0;
                    r_mcnt  <= '0;
                    if (!r_last) begin
                        r_state <= ST_IDLE;
                    end else if (n_sum_f == '0 || n_sum_s == '0 || n_sum_r == '0) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_MULP;
                    end
                end
                ST_MULP, ST_MULS: begin
                    if (r_mcnt == MCW'(ACC_BITS - 1)) begin
                        r_mcnt <= '0;
                        r_macc <= '0;
                        if (r_state == ST_MULP) begin
                            r_p     <= r_mb[0] ? r_macc + r_ma : r_macc;
                            r_ma    <= BIG_BITS'(r_sum_r);
                            r_mb    <= r_sum_r;
                            r_state <= ST_MULS;
                        end else begin
                            r_s     <= CMP_BITS'(r_mb[0] ? r_macc + r_ma : r_macc)
                                       << (2 * FRAC_BITS);
                            r_t     <= '0;
                            r_e     <= '0;
                            r_rr    <= CMP_BITS'(r_p) << (2 * FRAC_BITS);
                            r_q     <= '0;
                            r_qbit  <= SIM_BITS'(1) << FRAC_BITS;
                            r_state <= ST_SRCH;
                        end
                    end else begin
                        if (r_mb[0]) begin
                            r_macc <= r_macc + r_ma;
                        end
                        r_ma   <= r_ma << 1;
                        r_mb   <= r_mb >> 1;
                        r_mcnt <= r_mcnt + 1'b1;
                    end
                end
                ST_SRCH: begin
                    if (take) begin
                        r_t <= cand;
                        r_q <= r_q | r_qbit;
                        r_e <= (r_e + (r_rr << 1)) >> 1;
                    end else begin
                        r_e <= r_e >> 1;
                    end
                    r_rr   <= r_rr >> 2;
                    r_qbit <= r_qbit >> 1;
                    if (r_qbit[0]) begin
                        r_sim   <= take ? (r_q | r_qbit) : r_q;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (out_free) begin
                        r_out.similarity   <= r_sim;
                        r_out.empty_vector <= r_empty;
                        r_sum_f <= '0;
                        r_sum_s <= '0;
                        r_sum_r <= '0;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_sim_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> (r_out.similarity <= (SIM_BITS'(1) << FRAC_BITS)))
        else $error("similarity above one");
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_out.empty_vector) |-> (r_out.similarity == '0))
        else $error("empty vector with nonzero similarity");
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && out_free) |=> (r_sum_f == '0 && r_sum_r == '0))
        else $error("sums not cleared after result");
    a_q_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SRCH && r_q[FRAC_BITS]) |-> (r_q[FRAC_BITS-1:0] == '0))
        else $error("ratio search passed one");
`endif

endmodule
`default_nettype wire

FILE: test/bhattacharyya_coefficient_stream_top_test.sv
// self-checking testbench for the bhattacharyya coefficient stream top level
`timescale 1ns / 1ps
module bhattacharyya_coefficient_stream_top_test;
    import bcs_pkg::*;

    localparam int        WATCHDOG_LIMIT = 5000;
    localparam int        DRAIN_CYCLES   = 300;
    localparam logic [47:0] SUM_LIMIT    = 48'hFFFF_FFFF_FFFF;

    // running sums of one vector and the similarities still owed by the block
    class similarity_board;
        logic [47:0] weight_sum_u;
        logic [47:0] weight_sum_v;
        logic [47:0] root_sum;
        t_out_item   owed[$];
        int          errors;

        function new();
            weight_sum_u = '0;
            weight_sum_v = '0;
            root_sum     = '0;
            errors       = 0;
        endfunction

        function logic [47:0] add_clamped(logic [47:0] acc, logic [47:0] inc);
            logic [48:0] total;
            total = {1'b0, acc} + {1'b0, inc};
            return (total > {1'b0, SUM_LIMIT}) ? SUM_LIMIT : total[47:0];
        endfunction

        function logic [31:0] floor_root(logic [63:0] x);
            logic [63:0] r;
            logic [63:0] b;
            r = '0;
            b = 64'd1 << 62;
            while (b > x) b = b >> 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r[31:0];
        endfunction

        // largest q with q^2 * a * b <= s^2 * 2^32
        function logic [16:0] q16_ratio(logic [47:0] s, logic [47:0] a, logic [47:0] b);
            logic [191:0] ab;
            logic [191:0] rhs;
            logic [191:0] lhs;
            logic [31:0]  lo;
            logic [31:0]  hi;
            logic [31:0]  mid;
            ab  = 192'(a) * 192'(b);
            rhs = (192'(s) * 192'(s)) << 32;
            lo  = 0;
            hi  = 65536;
            while (lo < hi) begin
                mid = (lo + hi + 1) >> 1;
                lhs = 192'(mid) * 192'(mid) * ab;
                if (lhs <= rhs) lo = mid;
                else hi = mid - 1;
            end
            return lo[16:0];
        endfunction

        function void note_pair(t_in_item it);
            t_out_item res;
            weight_sum_u = add_clamped(weight_sum_u, 48'(it.u_value));
            weight_sum_v = add_clamped(weight_sum_v, 48'(it.v_value));
            if (it.u_value != 0 && it.v_value != 0)
                root_sum = add_clamped(root_sum,
                    48'(floor_root(64'(it.u_value) * 64'(it.v_value))));
            if (it.last_pair) begin
                res = '0;
                if (weight_sum_u == 0 || weight_sum_v == 0)
                    res.empty_vector = 1'b1;
                else if (root_sum != 0)
                    res.similarity = q16_ratio(root_sum, weight_sum_u, weight_sum_v);
                owed = {owed, res};
                weight_sum_u = '0;
                weight_sum_v = '0;
                root_sum     = '0;
            end
        endfunction

        function void check_result(t_out_item got);
            t_out_item want;
            if (owed.size() == 0) begin
                $error("unexpected result: similarity %0d empty_vector %0d",
                       got.similarity, got.empty_vector);
                errors++;
                return;
            end
            want = owed.pop_front();
            if (got.similarity !== want.similarity) begin
                $error("similarity: expected %0d, got %0d", want.similarity, got.similarity);
                errors++;
            end
            if (got.empty_vector !== want.empty_vector) begin
                $error("empty_vector: expected %0d, got %0d",
                       want.empty_vector, got.empty_vector);
                errors++;
            end
        endfunction
    endclass

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      in_ready;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;

    int        send_idle_pct = 0;
    int        recv_idle_pct = 0;
    int        quiet_cycles = 0;
    similarity_board board = new();

    bhattacharyya_coefficient_stream_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // monitors, receiver stalls and the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && in_ready) board.note_pair(in_data);
            if (out_valid && out_ready) board.check_result(out_data);
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("Test completed with failures");
                    $finish;
                end
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_pair(logic [31:0] u, logic [31:0] v, logic last);
        t_in_item it;
        it.u_value   = u;
        it.v_value   = v;
        it.last_pair = last;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge i_clk); while (!in_ready);
    endtask

    function automatic logic [31:0] pick_weight();
        case ($urandom_range(7))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom_range(15);
            3:       return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // one vector of random length, sometimes with one side zero throughout
    task automatic send_vector(output int pairs);
        int n;
        int shape;
        n = ($urandom_range(9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 6);
        shape = $urandom_range(9);
        for (int k = 0; k < n; k++) begin
            send_pair((shape == 0) ? 32'd0 : pick_weight(),
                      (shape == 1) ? 32'd0 : pick_weight(), k == n - 1);
        end
        pairs = n;
    endtask

    // one edge first so the last transfer is already on the board
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic random_phase(int sidle, int ridle, int count);
        int done;
        int n;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        done = 0;
        while (done < count) begin
            send_vector(n);
            done += n;
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty sums, extremes, no common support, multi-pair vectors
        send_pair(32'd0, 32'd0, 1'b1);
        send_pair(32'd0, 32'd5, 1'b1);
        send_pair(32'd7, 32'd0, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_pair(32'd1, 32'd1, 1'b1);
        send_pair(32'd5, 32'd0, 1'b0);
        send_pair(32'd0, 32'd9, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'd1, 1'b0);
        send_pair(32'd1, 32'hFFFF_FFFF, 1'b1);
        send_pair(32'd2, 32'd3, 1'b0);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
        send_pair(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b0);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        send_pair(32'd3, 32'd12, 1'b1);
        wait_drained();

        random_phase(29, 55, 500);
        wait_drained();
        random_phase(55, 29, 500);
        random_phase(0, 0, 500);
        wait_drained();

        if (board.errors == 0 && board.owed.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/bcs_pkg.sv
design/bcs_front.sv
design/bcs_back.sv
design/bhattacharyya_coefficient_stream_top.sv
test/bhattacharyya_coefficient_stream_top_test.sv
